[hw/rtl/ste_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types, constants and helpers for the symbol table engine.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int NAME_CHARS  = 8;
  localparam int VALUE_BITS  = 32;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W   = 32;
  localparam int MOD_W  = 16;
  localparam int NAME_W = 64;
  localparam int OUTV_W = 32;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    REQ_UPSERT    = 2'd0,
    REQ_FIND_NAME = 2'd1,
    REQ_FIND_ID   = 2'd2,
    REQ_DELETE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [MOD_W-1:0]  mod_id;
    logic [NAME_W-1:0] name;
    value_t            value;
  } row_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic done;
  } sts_t;

  // Name ends at its first zero byte; everything after it is cleared.
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] key);
    logic [NAME_W-1:0] res;
    logic              live;
    res  = '0;
    live = 1'b1;
    for (int k = 0; k < NAME_CHARS; k++) begin
      if (key[8*k +: 8] == 8'd0) live = 1'b0;
      if (live) res[8*k +: 8] = key[8*k +: 8];
    end
    return res;
  endfunction

endpackage

[hw/rtl/symbol_table_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_table_engine
// Linear-search symbol table: upsert, find by name, find by id, delete.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_* (valid/ready); each gives exactly one result on
//   out_* (valid/ready). in_req_type selects upsert, find by name, find by
//   id or delete by module. Names are normalized at the end of their first
//   zero byte before they are stored or compared.
//   The scan reads one row per cycle through the single read port, with
//   the compare in the cycle after the read; a hit stops it early. Delete
//   compacts the rows in the same pass through the single write port.
//   in_ready rises in the cycle after the result moves into the output
//   register. The next request is taken while an earlier result waits in
//   the output register; when the receiver stalls, a finished request
//   holds in the engine until the output register frees up.
//   Reset empties the table and restarts symbol ids at one.
// ----------------------------------------------------------------------------
module symbol_table_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_req_type,
  input  logic [ste_pkg::MOD_W-1:0]     in_module_id,
  input  logic [ste_pkg::NAME_W-1:0]    in_name_key,
  input  logic [31:0]                   in_new_value,
  input  logic [ste_pkg::ID_W-1:0]      in_symbol_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [ste_pkg::ID_W-1:0]      out_found_symbol_id,
  output logic [ste_pkg::MOD_W-1:0]     out_found_module_id,
  output logic [ste_pkg::NAME_W-1:0]    out_found_name,
  output logic [ste_pkg::OUTV_W-1:0]    out_found_value
);

  ste_pkg::cmd_t cmd;
  ste_pkg::sts_t sts;

  ste_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ste_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_req_type),
    .in_module_id        (in_module_id),
    .in_name_key         (in_name_key),
    .in_new_value        (in_new_value),
    .in_symbol_id        (in_symbol_id),
    .out_status          (out_status),
    .out_found_symbol_id (out_found_symbol_id),
    .out_found_module_id (out_found_module_id),
    .out_found_name      (out_found_name),
    .out_found_value     (out_found_value)
  );

endmodule

[hw/rtl/ste_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_ctrl
// Request sequencer: accept, table scan, result push to the output register.
// ----------------------------------------------------------------------------
module ste_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ste_pkg::sts_t sts,
  output ste_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUSH
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.scan   = (state_r == S_SCAN) && !sts.match && !sts.done;
    cmd.finish = (state_r == S_SCAN) && (sts.match || sts.done);
    cmd.push   = (state_r == S_PUSH) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (cmd.finish) state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (cmd.push) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ready))
    else $error("result pushed over a pending result");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SCAN))
    else $error("accepted request did not start a scan");

  a_finish_push: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == S_PUSH) && !in_ready)
    else $error("finished scan did not move to push");

endmodule

[hw/rtl/ste_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_datapath
// Row memory, scan pointers, compaction, counters and result registers.
// ----------------------------------------------------------------------------
module ste_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ste_pkg::cmd_t                 cmd,
  output ste_pkg::sts_t                 sts,
  input  logic [1:0]                    in_req_type,
  input  logic [ste_pkg::MOD_W-1:0]     in_module_id,
  input  logic [ste_pkg::NAME_W-1:0]    in_name_key,
  input  logic [31:0]                   in_new_value,
  input  logic [ste_pkg::ID_W-1:0]      in_symbol_id,
  output logic [1:0]                    out_status,
  output logic [ste_pkg::ID_W-1:0]      out_found_symbol_id,
  output logic [ste_pkg::MOD_W-1:0]     out_found_module_id,
  output logic [ste_pkg::NAME_W-1:0]    out_found_name,
  output logic [ste_pkg::OUTV_W-1:0]    out_found_value
);

  ste_pkg::row_t mem [ste_pkg::TABLE_DEPTH];

  ste_pkg::req_t                   req_r;
  logic [ste_pkg::MOD_W-1:0]       mod_r;
  logic [ste_pkg::NAME_W-1:0]      name_r;
  ste_pkg::value_t                 val_r;
  logic [ste_pkg::ID_W-1:0]        sid_r;

  ste_pkg::cnt_t                   count_r, count_nxt;
  logic [ste_pkg::ID_W-1:0]        next_id_r, next_id_nxt;
  ste_pkg::cnt_t                   rd_idx_r, rd_idx_nxt;
  logic                            rd_vld_r, rd_vld_nxt;
  ste_pkg::cnt_t                   wr_idx_r, wr_idx_nxt;
  logic [ste_pkg::IDX_W-1:0]       rd_addr_r;
  ste_pkg::row_t                   rdata_r;

  ste_pkg::status_t                res_status_r;
  ste_pkg::row_t                   res_row_r;
  ste_pkg::status_t                out_status_r;
  ste_pkg::row_t                   out_row_r;

  logic                            more;
  logic                            rd_en;
  logic                            match;
  logic                            full;
  logic                            keep;
  logic                            wr_en;
  logic [ste_pkg::IDX_W-1:0]       wr_addr;
  ste_pkg::row_t                   wr_row;
  ste_pkg::row_t                   new_row;
  ste_pkg::row_t                   hit_row;

  assign more  = (rd_idx_r < count_r);
  assign rd_en = cmd.scan && more;
  assign full  = (count_r == ste_pkg::cnt_t'(ste_pkg::TABLE_DEPTH));
  assign keep  = rd_vld_r && (rdata_r.mod_id != mod_r);

  always_comb begin
    match = 1'b0;
    unique case (req_r)
      ste_pkg::REQ_UPSERT:    match = (rdata_r.mod_id == mod_r) && (rdata_r.name == name_r);
      ste_pkg::REQ_FIND_NAME: match = (rdata_r.name == name_r);
      ste_pkg::REQ_FIND_ID:   match = (rdata_r.id == sid_r);
      ste_pkg::REQ_DELETE:    match = 1'b0;
      default:                match = 1'b0;
    endcase
    match = match && rd_vld_r;
  end

  assign sts.match = match;
  assign sts.done  = !rd_vld_r && !more;

  always_comb begin
    new_row        = '0;
    new_row.id     = next_id_r;
    new_row.mod_id = mod_r;
    new_row.name   = name_r;
    new_row.value  = val_r;
    hit_row        = rdata_r;
    if (req_r == ste_pkg::REQ_UPSERT) hit_row.value = val_r;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx_r[ste_pkg::IDX_W-1:0];
    wr_row  = rdata_r;
    if (cmd.scan && (req_r == ste_pkg::REQ_DELETE) && keep) begin
      wr_en = 1'b1;
    end
    if (cmd.finish && (req_r == ste_pkg::REQ_UPSERT)) begin
      if (match) begin
        wr_en   = 1'b1;
        wr_addr = rd_addr_r;
        wr_row  = hit_row;
      end else if (!full) begin
        wr_en   = 1'b1;
        wr_addr = count_r[ste_pkg::IDX_W-1:0];
        wr_row  = new_row;
      end
    end
  end

  always_comb begin
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    rd_idx_nxt  = rd_idx_r;
    rd_vld_nxt  = 1'b0;
    wr_idx_nxt  = wr_idx_r;
    if (cmd.load) begin
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
    end
    if (cmd.scan) begin
      rd_vld_nxt = rd_en;
      if (rd_en) rd_idx_nxt = rd_idx_r + ste_pkg::cnt_t'(1);
      if ((req_r == ste_pkg::REQ_DELETE) && keep) wr_idx_nxt = wr_idx_r + ste_pkg::cnt_t'(1);
    end
    if (cmd.finish && !match) begin
      if ((req_r == ste_pkg::REQ_UPSERT) && !full) begin
        count_nxt   = count_r + ste_pkg::cnt_t'(1);
        next_id_nxt = next_id_r + ste_pkg::ID_W'(1);
      end else if (req_r == ste_pkg::REQ_DELETE) begin
        count_nxt = wr_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      next_id_r <= ste_pkg::ID_W'(1);
      rd_idx_r  <= '0;
      rd_vld_r  <= 1'b0;
      wr_idx_r  <= '0;
    end else begin
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      rd_idx_r  <= rd_idx_nxt;
      rd_vld_r  <= rd_vld_nxt;
      wr_idx_r  <= wr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r   <= mem[rd_idx_r[ste_pkg::IDX_W-1:0]];
      rd_addr_r <= rd_idx_r[ste_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= ste_pkg::req_t'(in_req_type);
      mod_r  <= in_module_id;
      name_r <= ste_pkg::norm_name(in_name_key);
      val_r  <= ste_pkg::value_t'(in_new_value);
      sid_r  <= in_symbol_id;
    end
    if (cmd.finish) begin
      if (match) begin
        res_status_r <= ste_pkg::ST_OK;
        res_row_r    <= hit_row;
      end else begin
        res_row_r <= '0;
        unique case (req_r) inside
          ste_pkg::REQ_UPSERT: begin
            if (full) begin
              res_status_r <= ste_pkg::ST_FULL;
            end else begin
              res_status_r <= ste_pkg::ST_OK;
              res_row_r    <= new_row;
            end
          end
          ste_pkg::REQ_FIND_NAME, ste_pkg::REQ_FIND_ID: res_status_r <= ste_pkg::ST_NOT_FOUND;
          ste_pkg::REQ_DELETE:                          res_status_r <= ste_pkg::ST_OK;
          default:                                      res_status_r <= ste_pkg::ST_OK;
        endcase
      end
    end
    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_row_r    <= res_row_r;
    end
  end

  assign out_status          = out_status_r;
  assign out_found_symbol_id = out_row_r.id;
  assign out_found_module_id = out_row_r.mod_id;
  assign out_found_name      = out_row_r.name;
  assign out_found_value     = ste_pkg::OUTV_W'(out_row_r.value);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ste_pkg::cnt_t'(ste_pkg::TABLE_DEPTH))
    else $error("row count beyond table depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && (req_r == ste_pkg::REQ_DELETE) && keep)
      |-> (wr_idx_r <= ste_pkg::cnt_t'(rd_addr_r)))
    else $error("compaction write ahead of its source row");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && !match && (req_r == ste_pkg::REQ_UPSERT) && !full)
      |=> (count_r == $past(count_r) + ste_pkg::cnt_t'(1)))
    else $error("append did not grow the table");

endmodule

[test/ste_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_checker
// Watches both channels of the symbol table engine, keeps its own copy of
// the table, predicts the reply to every accepted request and compares each
// accepted reply field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ste_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic [ste_pkg::MOD_W-1:0]  in_module_id,
  input  logic [ste_pkg::NAME_W-1:0] in_name_key,
  input  logic [31:0]                in_new_value,
  input  logic [ste_pkg::ID_W-1:0]   in_symbol_id,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [1:0]                 out_status,
  input  logic [ste_pkg::ID_W-1:0]   out_found_symbol_id,
  input  logic [ste_pkg::MOD_W-1:0]  out_found_module_id,
  input  logic [ste_pkg::NAME_W-1:0] out_found_name,
  input  logic [ste_pkg::OUTV_W-1:0] out_found_value,
  output int                         fail_count,
  output int                         pending
);
  import ste_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [MOD_W-1:0]   mod_id;
    logic [NAME_W-1:0]  name;
    logic [OUTV_W-1:0]  value;
  } reply_t;

  row_t            rows [TABLE_DEPTH];
  int              row_total = 0;
  logic [ID_W-1:0] id_counter = 1;
  reply_t          predicted_replies [$];
  int              errors = 0;

  // Only the bytes before the first zero byte are part of the name.
  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] key);
    logic [NAME_W-1:0] keep;
    int                len;
    len  = NAME_CHARS;
    keep = '0;
    for (int k = NAME_CHARS - 1; k >= 0; k--)
      if (key[8*k +: 8] == 8'h00) len = k;
    for (int k = 0; k < len; k++) keep[8*k +: 8] = 8'hFF;
    return key & keep;
  endfunction

  task automatic apply_request(input req_t kind, input logic [MOD_W-1:0] mod,
                               input logic [NAME_W-1:0] key, input logic [31:0] val,
                               input logic [ID_W-1:0] sid, output reply_t reply);
    logic [NAME_W-1:0] name;
    int                hit;
    int                w;
    name  = trim_name(key);
    reply = '0;
    hit   = -1;
    case (kind)
      REQ_UPSERT: begin
        for (int i = 0; i < row_total; i++)
          if (hit < 0 && rows[i].mod_id == mod && rows[i].name == name) hit = i;
        if (hit >= 0) begin
          rows[hit].value = value_t'(val);
        end else if (row_total == TABLE_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          hit                = row_total;
          rows[hit].id       = id_counter;
          rows[hit].mod_id   = mod;
          rows[hit].name     = name;
          rows[hit].value    = value_t'(val);
          id_counter         = id_counter + 1;
          row_total          = row_total + 1;
        end
      end
      REQ_FIND_NAME: begin
        for (int i = 0; i < row_total; i++)
          if (hit < 0 && rows[i].name == name) hit = i;
        if (hit < 0) reply.status = ST_NOT_FOUND;
      end
      REQ_FIND_ID: begin
        for (int i = 0; i < row_total; i++)
          if (hit < 0 && rows[i].id == sid) hit = i;
        if (hit < 0) reply.status = ST_NOT_FOUND;
      end
      default: begin
        w = 0;
        for (int i = 0; i < row_total; i++) begin
          if (rows[i].mod_id != mod) begin
            rows[w] = rows[i];
            w++;
          end
        end
        row_total = w;
      end
    endcase
    if (hit >= 0) begin
      reply.id     = rows[hit].id;
      reply.mod_id = rows[hit].mod_id;
      reply.name   = rows[hit].name;
      reply.value  = OUTV_W'(rows[hit].value);
    end
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      row_total  = 0;
      id_counter = 1;
      predicted_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: reply with no request pending, expected none, actual status %0d",
                   $time, out_status);
          errors++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("found_symbol_id", 64'(want.id), 64'(out_found_symbol_id));
          check_field("found_module_id", 64'(want.mod_id), 64'(out_found_module_id));
          check_field("found_name", want.name, out_found_name);
          check_field("found_value", 64'(want.value), 64'(out_found_value));
        end
      end
      if (in_valid && in_ready) begin
        apply_request(req_t'(in_req_type), in_module_id, in_name_key, in_new_value,
                      in_symbol_id, got);
        predicted_replies.push_back(got);
      end
    end
    fail_count <= errors;
    pending    <= predicted_replies.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Request stimulus for the symbol table engine: a directed opening on lookups,
// name trimming, replace, append and delete, then random requests in blocks
// that fill, churn or drain the table, under several sender and receiver
// idling phases, a long receiver hold-off and full drains between phases.
// ----------------------------------------------------------------------------
module tb;
  import ste_pkg::*;

  localparam int MODE_MIX   = 0;
  localparam int MODE_FILL  = 1;
  localparam int MODE_DRAIN = 2;
  localparam int NAME_POOL  = 12;
  localparam int LONG_HOLD  = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  req_t              in_req_type = REQ_UPSERT;
  logic [MOD_W-1:0]  in_module_id = '0;
  logic [NAME_W-1:0] in_name_key = '0;
  logic [31:0]       in_new_value = '0;
  logic [ID_W-1:0]   in_symbol_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [ID_W-1:0]   out_found_symbol_id;
  logic [MOD_W-1:0]  out_found_module_id;
  logic [NAME_W-1:0] out_found_name;
  logic [OUTV_W-1:0] out_found_value;

  int                fail_count;
  int                pending;
  int                idle_pct = 0;
  int                stall_pct = 0;
  logic              hold_start = 1'b0;
  int                hold_left = 0;
  int                upserts = 0;
  logic [MOD_W-1:0]  mod_pool [4] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
  logic [NAME_W-1:0] name_pool [NAME_POOL];
  int                name_len [NAME_POOL];

  symbol_table_engine i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_module_id        (in_module_id),
    .in_name_key         (in_name_key),
    .in_new_value        (in_new_value),
    .in_symbol_id        (in_symbol_id),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_found_symbol_id (out_found_symbol_id),
    .out_found_module_id (out_found_module_id),
    .out_found_name      (out_found_name),
    .out_found_value     (out_found_value)
  );

  ste_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_module_id        (in_module_id),
    .in_name_key         (in_name_key),
    .in_new_value        (in_new_value),
    .in_symbol_id        (in_symbol_id),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_found_symbol_id (out_found_symbol_id),
    .out_found_module_id (out_found_module_id),
    .out_found_name      (out_found_name),
    .out_found_value     (out_found_value),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_start) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(input req_t kind, input logic [MOD_W-1:0] mod,
                              input logic [NAME_W-1:0] key, input logic [31:0] val,
                              input logic [ID_W-1:0] sid);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_module_id <= mod;
    in_name_key  <= key;
    in_new_value <= val;
    in_symbol_id <= sid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == REQ_UPSERT) upserts++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Pool names, sometimes with junk behind the terminator, or fully random keys.
  function automatic logic [NAME_W-1:0] pick_name(input int noise_pct);
    logic [NAME_W-1:0] n;
    int                k;
    if ($urandom_range(99) < noise_pct) return {$urandom, $urandom};
    k = $urandom_range(NAME_POOL - 1);
    n = name_pool[k];
    if (name_len[k] < 7 && $urandom_range(3) == 0)
      n = n | ({$urandom, $urandom} << (8 * (name_len[k] + 1)));
    return n;
  endfunction

  task automatic random_request(input int mode);
    req_t             kind;
    int               roll;
    logic [MOD_W-1:0] mod;
    logic [ID_W-1:0]  sid;
    roll = $urandom_range(99);
    if (mode == MODE_FILL) begin
      if (roll < 85) kind = REQ_UPSERT;
      else if (roll < 93) kind = REQ_FIND_NAME;
      else kind = REQ_FIND_ID;
    end else if (mode == MODE_DRAIN) begin
      if (roll < 20) kind = REQ_UPSERT;
      else if (roll < 45) kind = REQ_FIND_NAME;
      else if (roll < 70) kind = REQ_FIND_ID;
      else kind = REQ_DELETE;
    end else begin
      if (roll < 45) kind = REQ_UPSERT;
      else if (roll < 70) kind = REQ_FIND_NAME;
      else if (roll < 92) kind = REQ_FIND_ID;
      else kind = REQ_DELETE;
    end
    if ($urandom_range(99) < 10) mod = MOD_W'($urandom);
    else mod = mod_pool[$urandom_range(3)];
    if ($urandom_range(99) < 20) sid = $urandom;
    else sid = $urandom_range(upserts + 2);
    send_request(kind, mod, pick_name(mode == MODE_FILL ? 60 : 10), $urandom, sid);
  endtask

  task automatic run_phase(input int sender_idle, input int receiver_stall,
                           input int count);
    int mode;
    mode      = MODE_MIX;
    idle_pct  = sender_idle;
    stall_pct <= receiver_stall;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) mode = $urandom_range(MODE_DRAIN);
      random_request(mode);
    end
    drain();
  endtask

  initial begin
    for (int k = 0; k < NAME_POOL; k++) begin
      name_len[k]  = k % 8 + 1;
      name_pool[k] = '0;
      for (int b = 0; b < name_len[k]; b++) name_pool[k][8*b +: 8] = $urandom_range(255, 1);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(REQ_FIND_NAME, 16'h0000, 64'h41, 32'h0, 32'h0);
    send_request(REQ_FIND_ID, 16'h0000, 64'h0, 32'h0, 32'h1);
    send_request(REQ_DELETE, 16'h0000, 64'h0, 32'h0, 32'h0);
    send_request(REQ_UPSERT, 16'h0000, 64'h0, 32'h0, 32'h0);
    send_request(REQ_UPSERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_UPSERT, 16'h0001, 64'hDEAD_BEEF_CA00_6261, 32'h1234_5678, 32'h0);
    send_request(REQ_UPSERT, 16'h0002, 64'h0000_0000_0000_6261, 32'h5, 32'h0);
    send_request(REQ_FIND_NAME, 16'h0000, 64'h1234_5600_0000_6261, 32'h0, 32'h0);
    send_request(REQ_UPSERT, 16'h0001, 64'h6261, 32'd77, 32'h0);
    send_request(REQ_FIND_ID, 16'h0000, 64'h0, 32'h0, 32'd3);
    send_request(REQ_FIND_ID, 16'h0000, 64'h0, 32'h0, 32'h0);
    send_request(REQ_FIND_ID, 16'h0000, 64'h0, 32'h0, 32'hFFFF_FFFF);
    send_request(REQ_FIND_NAME, 16'h0000, 64'h0, 32'h0, 32'h0);
    send_request(REQ_FIND_NAME, 16'h0000, 64'hFFFF_FFFF_FFFF_FF00, 32'h0, 32'h0);
    send_request(REQ_FIND_NAME, 16'h0000, 64'h7A, 32'h0, 32'h0);
    send_request(REQ_DELETE, 16'h0001, 64'h0, 32'h0, 32'h0);
    send_request(REQ_FIND_NAME, 16'h0000, 64'h6261, 32'h0, 32'h0);
    send_request(REQ_FIND_ID, 16'h0000, 64'h0, 32'h0, 32'd3);
    send_request(REQ_DELETE, 16'h1234, 64'h0, 32'h0, 32'h0);
    send_request(REQ_UPSERT, 16'h0001, 64'h6261, 32'hA5A5_A5A5, 32'h0);
    send_request(REQ_FIND_ID, 16'h0000, 64'h0, 32'h0, 32'd2);
    send_request(REQ_DELETE, 16'hFFFF, 64'h0, 32'h0, 32'h0);
    send_request(REQ_FIND_NAME, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0);
    drain();

    run_phase(0, 0, 250);

    // long receiver hold-off while requests keep coming
    stall_pct  <= 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < 60; i++) random_request(MODE_MIX);
    drain();

    run_phase(65, 0, 250);
    run_phase(0, 65, 250);
    run_phase(38, 38, 240);

    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
